>>> src/cpa_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpa_pkg: shared types and constants of the contiguous page allocator
// Sizes, codes, microcode control word and the microcode program.
// ----------------------------------------------------------------------------
package cpa_pkg;

  localparam int MAX_FRAMES = 1024;
  localparam int PAGE_BYTES = 4096;

  localparam int ADDR_W     = 32;
  localparam int NUM_W      = 11;   // num_frames and page_count fields
  localparam int STATUS_W   = 2;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 32;

  localparam int IDX_W      = $clog2(MAX_FRAMES);
  localparam int CNT_RAW_W  = $clog2(MAX_FRAMES + 1);
  localparam int CNT_W      = (CNT_RAW_W > NUM_W) ? CNT_RAW_W : NUM_W;
  localparam int PAGE_SHIFT = $clog2(PAGE_BYTES);
  localparam int PG_W       = ADDR_W - PAGE_SHIFT;

  localparam int SIZE_RST_I = (1024 > MAX_FRAMES) ? MAX_FRAMES : 1024;
  localparam logic [CNT_W-1:0] SIZE_RST = CNT_W'(SIZE_RST_I);
  localparam logic [CNT_W-1:0] MAX_CNT  = CNT_W'(MAX_FRAMES);

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_BASE_ADDR  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_NUM_FRAMES = 1'b1;

  // request opcodes
  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK      = 2'd0,
    ST_NOSPACE = 2'd1,
    ST_BADADDR = 2'd2
  } status_t;

  // microcode addresses
  typedef enum logic [3:0] {
    U_CLR  = 4'd0,   // clearing sweep after reset
    U_IDLE = 4'd1,   // wait for a request, dispatch on op
    U_A0   = 4'd2,   // alloc: zero count check, start scan
    U_A1   = 4'd3,   // alloc: end check, read entry
    U_A2   = 4'd4,   // alloc: update run, loop until hit
    U_A3   = 4'd5,   // alloc: rewind to run start, form address
    U_A4   = 4'd6,   // alloc: number the run
    U_AOK  = 4'd7,
    U_NOSP = 4'd8,
    U_F1   = 4'd9,   // free: range check, index from address
    U_F2   = 4'd10,  // free: clear entry
    U_F3   = 4'd11,  // free: end check, read next entry
    U_F4   = 4'd12,  // free: continue while entry is a run tail
    U_FOK  = 4'd13,
    U_BAD  = 4'd14
  } upc_t;

  typedef enum logic [3:0] {
    C_NONE, C_ALWAYS, C_N_ZERO, C_PTR_END, C_RUN_MISS,
    C_CNT_MORE, C_BAD, C_RD_MORE, C_CLR_MORE
  } cond_t;

  typedef enum logic [2:0] {P_HOLD, P_ZERO, P_INC, P_FIRST, P_PAGE} ptr_op_t;
  typedef enum logic [1:0] {M_NONE, M_READ, M_WR_ZERO, M_WR_CNT} mem_op_t;
  typedef enum logic [1:0] {R_HOLD, R_ZERO, R_EVAL} run_op_t;
  typedef enum logic [1:0] {K_HOLD, K_ZERO, K_INC} cnt_op_t;

  typedef struct packed {
    cond_t   cond;
    upc_t    target;
    ptr_op_t ptr_op;
    mem_op_t mem_op;
    run_op_t run_op;
    cnt_op_t cnt_op;
    logic    addr_run;   // load result address from run start
    logic    wait_in;    // idle step: ready for a request
    logic    finish;     // deliver result, back to idle
    logic    res_addr;   // result carries the address register
    status_t status;
  } ctrl_t;

  // datapath flags seen by the sequencer
  typedef struct packed {
    logic in_acc;
    logic in_free;
    logic n_zero;
    logic ptr_end;
    logic run_miss;
    logic cnt_more;
    logic bad;
    logic rd_more;
    logic clr_more;
    logic out_free;
  } flags_t;

  localparam ctrl_t CTRL_NOP = '{
    cond: C_NONE, target: U_IDLE, ptr_op: P_HOLD, mem_op: M_NONE,
    run_op: R_HOLD, cnt_op: K_HOLD, addr_run: 1'b0, wait_in: 1'b0,
    finish: 1'b0, res_addr: 1'b0, status: ST_OK
  };

  // microcode ROM
  function automatic ctrl_t ucode(input upc_t pc);
    ctrl_t c;
    c = CTRL_NOP;
    case (pc)
      U_CLR: begin
        c.mem_op = M_WR_ZERO;  c.ptr_op = P_INC;
        c.cond   = C_CLR_MORE; c.target = U_CLR;
      end
      U_IDLE: begin
        c.wait_in = 1'b1;
      end
      U_A0: begin
        c.cond   = C_N_ZERO; c.target = U_NOSP;
        c.ptr_op = P_ZERO;   c.run_op = R_ZERO;
      end
      U_A1: begin
        c.cond   = C_PTR_END; c.target = U_NOSP;
        c.mem_op = M_READ;
      end
      U_A2: begin
        c.cond   = C_RUN_MISS; c.target = U_A1;
        c.run_op = R_EVAL;     c.ptr_op = P_INC;
      end
      U_A3: begin
        c.ptr_op = P_FIRST; c.cnt_op = K_ZERO; c.addr_run = 1'b1;
      end
      U_A4: begin
        c.mem_op = M_WR_CNT;   c.ptr_op = P_INC; c.cnt_op = K_INC;
        c.cond   = C_CNT_MORE; c.target = U_A4;
      end
      U_AOK: begin
        c.finish = 1'b1; c.res_addr = 1'b1; c.status = ST_OK;
      end
      U_NOSP: begin
        c.finish = 1'b1; c.status = ST_NOSPACE;
      end
      U_F1: begin
        c.cond   = C_BAD; c.target = U_BAD;
        c.ptr_op = P_PAGE;
      end
      U_F2: begin
        c.mem_op = M_WR_ZERO; c.ptr_op = P_INC;
      end
      U_F3: begin
        c.cond   = C_PTR_END; c.target = U_FOK;
        c.mem_op = M_READ;
      end
      U_F4: begin
        c.cond = C_RD_MORE; c.target = U_F2;
      end
      U_FOK: begin
        c.finish = 1'b1; c.status = ST_OK;
      end
      U_BAD: begin
        c.finish = 1'b1; c.status = ST_BADADDR;
      end
      default: begin
        c.cond = C_ALWAYS; c.target = U_IDLE;
      end
    endcase
    return c;
  endfunction

endpackage

>>> src/cpa_req_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpa_req_if: request channel
// Valid/ready channel carrying one allocate or free request.
// ----------------------------------------------------------------------------
interface cpa_req_if;
  logic                       valid;
  logic                       ready;
  logic                       op;
  logic [cpa_pkg::NUM_W-1:0]  page_count;
  logic [cpa_pkg::ADDR_W-1:0] free_addr;

  modport source (output valid, output op, output page_count, output free_addr,
                  input ready);
  modport sink   (input valid, input op, input page_count, input free_addr,
                  output ready);
endinterface

>>> src/cpa_rsp_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpa_rsp_if: response channel
// Valid/ready channel carrying one allocator response.
// ----------------------------------------------------------------------------
interface cpa_rsp_if;
  logic                         valid;
  logic                         ready;
  logic [cpa_pkg::ADDR_W-1:0]   alloc_addr;
  logic [cpa_pkg::STATUS_W-1:0] status;

  modport source (output valid, output alloc_addr, output status, input ready);
  modport sink   (input valid, input alloc_addr, input status, output ready);
endinterface

>>> src/contiguous_page_allocator_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// contiguous_page_allocator_top: first-fit contiguous page frame allocator
//
// Requests arrive on in_ch (op, page_count, free_addr); each gives exactly one
// response on out_ch (alloc_addr, status). Both are valid/ready channels; a
// transfer happens when valid and ready are high at a rising edge.
// cfg_we/cfg_idx/cfg_wdata write base_addr (index 0) and num_frames (index 1);
// the user must write them only while the block is idle; the block does not enforce it.
// One request at a time, run by a microcode sequencer over a single-port
// frame map memory (one access per cycle). Allocate scans the map for the
// first free run of page_count entries, then numbers the run; free clears
// the entries of one run, starting at its head.
// After reset a clearing sweep writes all MAX_FRAMES entries to zero, one per
// cycle; in_ch.ready stays low until it is done.
// The response sits in an output register; the next request is taken while
// it waits. If the receiver stalls, the sequencer holds at its final step
// until the output register frees up.
// ----------------------------------------------------------------------------
module contiguous_page_allocator_top (
  input  logic                              clk,
  input  logic                              rst_n,
  cpa_req_if.sink                           in_ch,
  cpa_rsp_if.source                         out_ch,
  input  logic                              cfg_we,
  input  logic [cpa_pkg::CFG_IDX_W-1:0]     cfg_idx,
  input  logic [cpa_pkg::CFG_DATA_W-1:0]    cfg_wdata
);

  localparam int CNT_W = cpa_pkg::CNT_W;

  // configuration
  logic [cpa_pkg::ADDR_W-1:0] base_r;
  logic [CNT_W-1:0]           size_r;       // clamped num_frames
  logic [CNT_W-1:0]           num_ext;

  // datapath
  logic [CNT_W-1:0]           ptr_r, ptr_nxt;
  logic [CNT_W-1:0]           run_r, run_nxt, run_eval;
  logic [CNT_W-1:0]           cnt_r, cnt_nxt;
  logic [CNT_W-1:0]           n_r;
  logic [cpa_pkg::ADDR_W-1:0] addr_r;       // free offset, then result address
  logic [CNT_W-1:0]           first1;       // run start + 1
  logic [cpa_pkg::PG_W-1:0]   pg;

  // frame map
  logic [CNT_W-1:0]           frame_map [cpa_pkg::MAX_FRAMES];
  logic [CNT_W-1:0]           rdata_r;
  logic [cpa_pkg::IDX_W-1:0]  mem_idx;
  logic                       mem_we;
  logic [CNT_W-1:0]           mem_wdata;

  // output register
  logic                         out_valid_r;
  logic [cpa_pkg::ADDR_W-1:0]   out_addr_r;
  cpa_pkg::status_t             out_status_r;

  cpa_pkg::ctrl_t  ctrl;
  cpa_pkg::flags_t flags;
  logic            in_acc;
  logic            fire;

  cpa_useq u_useq (
    .clk   (clk),
    .rst_n (rst_n),
    .flags (flags),
    .ctrl  (ctrl)
  );

  // --- configuration registers ---
  assign num_ext = CNT_W'(cfg_wdata[cpa_pkg::NUM_W-1:0]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r <= '0;
      size_r <= cpa_pkg::SIZE_RST;
    end else if (cfg_we) begin
      case (cfg_idx)
        cpa_pkg::REG_BASE_ADDR:  base_r <= cfg_wdata[cpa_pkg::ADDR_W-1:0];
        cpa_pkg::REG_NUM_FRAMES: size_r <= (num_ext > cpa_pkg::MAX_CNT) ?
                                           cpa_pkg::MAX_CNT : num_ext;
        default: ;
      endcase
    end
  end

  // --- request intake ---
  assign in_ch.ready = ctrl.wait_in;
  assign in_acc      = in_ch.valid && in_ch.ready;

  // --- datapath ---
  assign run_eval = (rdata_r == '0) ? run_r + CNT_W'(1) : '0;
  assign first1   = ptr_r - n_r + CNT_W'(1);
  assign pg       = addr_r[cpa_pkg::ADDR_W-1:cpa_pkg::PAGE_SHIFT];

  always_comb begin
    case (ctrl.ptr_op)
      cpa_pkg::P_HOLD:  ptr_nxt = ptr_r;
      cpa_pkg::P_ZERO:  ptr_nxt = '0;
      cpa_pkg::P_INC:   ptr_nxt = ptr_r + CNT_W'(1);
      cpa_pkg::P_FIRST: ptr_nxt = ptr_r - n_r;
      cpa_pkg::P_PAGE:  ptr_nxt = CNT_W'(pg - cpa_pkg::PG_W'(1));
      default:          ptr_nxt = ptr_r;
    endcase
    case (ctrl.run_op)
      cpa_pkg::R_ZERO: run_nxt = '0;
      cpa_pkg::R_EVAL: run_nxt = run_eval;
      default:         run_nxt = run_r;
    endcase
    case (ctrl.cnt_op)
      cpa_pkg::K_ZERO: cnt_nxt = '0;
      cpa_pkg::K_INC:  cnt_nxt = cnt_r + CNT_W'(1);
      default:         cnt_nxt = cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ptr_r <= '0;
    end else begin
      ptr_r <= ptr_nxt;
    end
  end

  always_ff @(posedge clk) begin
    run_r <= run_nxt;
    cnt_r <= cnt_nxt;
    if (in_acc) begin
      n_r    <= CNT_W'(in_ch.page_count);
      addr_r <= in_ch.free_addr - base_r;
    end else if (ctrl.addr_run) begin
      addr_r <= base_r + (cpa_pkg::ADDR_W'(first1) << cpa_pkg::PAGE_SHIFT);
    end
  end

  // --- frame map memory: one access per cycle, registered read ---
  assign mem_idx   = ptr_r[cpa_pkg::IDX_W-1:0];
  assign mem_we    = (ctrl.mem_op == cpa_pkg::M_WR_ZERO) ||
                     (ctrl.mem_op == cpa_pkg::M_WR_CNT);
  assign mem_wdata = (ctrl.mem_op == cpa_pkg::M_WR_CNT) ? cnt_r + CNT_W'(1) : '0;

  always_ff @(posedge clk) begin
    if (mem_we) frame_map[mem_idx] <= mem_wdata;
    if (ctrl.mem_op == cpa_pkg::M_READ) rdata_r <= frame_map[mem_idx];
  end

  // --- sequencer flags ---
  always_comb begin
    flags.in_acc   = in_acc;
    flags.in_free  = (in_ch.op == cpa_pkg::OP_FREE);
    flags.n_zero   = (n_r == '0);
    flags.ptr_end  = (ptr_r >= size_r);
    flags.run_miss = (run_eval != n_r);
    flags.cnt_more = ((cnt_r + CNT_W'(1)) != n_r);
    flags.bad      = (pg == '0) || (cpa_pkg::ADDR_W'(pg) > cpa_pkg::ADDR_W'(size_r));
    flags.rd_more  = (rdata_r != '0) && (rdata_r != CNT_W'(1));
    flags.clr_more = (ptr_r != cpa_pkg::MAX_CNT - CNT_W'(1));
    flags.out_free = !out_valid_r || out_ch.ready;
  end

  // --- response register ---
  assign fire = ctrl.finish && flags.out_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (fire) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_addr_r   <= ctrl.res_addr ? addr_r : '0;
      out_status_r <= ctrl.status;
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.alloc_addr = out_addr_r;
  assign out_ch.status     = out_status_r;

`ifndef ASSERT_OFF
  // map writes stay inside the store
  a_wr_bound: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |-> (ptr_r < cpa_pkg::MAX_CNT))
    else $error("frame map write out of range");

  // run numbering never exceeds the requested length
  a_num_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (ctrl.mem_op == cpa_pkg::M_WR_CNT) |-> (cnt_r < n_r))
    else $error("run numbering past page_count");

  // one request in flight: intake closes right after a transfer
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> !in_ch.ready)
    else $error("second request taken while busy");

  // a pending response is not overwritten
  a_no_clobber: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ch.ready) |-> !fire)
    else $error("response overwritten while stalled");
`endif

endmodule

>>> src/cpa_useq.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpa_useq: microcode sequencer
// Step counter, control ROM and condition/jump logic.
// ----------------------------------------------------------------------------
module cpa_useq (
  input  logic             clk,
  input  logic             rst_n,
  input  cpa_pkg::flags_t  flags,
  output cpa_pkg::ctrl_t   ctrl
);

  cpa_pkg::upc_t upc_r, upc_nxt;
  logic          take;

  assign ctrl = cpa_pkg::ucode(upc_r);

  always_comb begin
    case (ctrl.cond)
      cpa_pkg::C_NONE:     take = 1'b0;
      cpa_pkg::C_ALWAYS:   take = 1'b1;
      cpa_pkg::C_N_ZERO:   take = flags.n_zero;
      cpa_pkg::C_PTR_END:  take = flags.ptr_end;
      cpa_pkg::C_RUN_MISS: take = flags.run_miss;
      cpa_pkg::C_CNT_MORE: take = flags.cnt_more;
      cpa_pkg::C_BAD:      take = flags.bad;
      cpa_pkg::C_RD_MORE:  take = flags.rd_more;
      cpa_pkg::C_CLR_MORE: take = flags.clr_more;
      default:             take = 1'b0;
    endcase
  end

  always_comb begin
    if (ctrl.wait_in) begin
      if (flags.in_acc) upc_nxt = flags.in_free ? cpa_pkg::U_F1 : cpa_pkg::U_A0;
      else              upc_nxt = upc_r;
    end else if (ctrl.finish) begin
      upc_nxt = flags.out_free ? cpa_pkg::U_IDLE : upc_r;
    end else if (take) begin
      upc_nxt = ctrl.target;
    end else begin
      upc_nxt = cpa_pkg::upc_t'(4'(upc_r) + 4'd1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) upc_r <= cpa_pkg::U_CLR;
    else        upc_r <= upc_nxt;
  end

endmodule
